// File: hdl/split_ring_packet_queue_defines.svh
// ---------------------------------------------------------------------------
// Split ring packet queue assertion macros
// Clocked, reset-gated property wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef SPLIT_RING_PACKET_QUEUE_DEFINES_SVH
`define SPLIT_RING_PACKET_QUEUE_DEFINES_SVH

// same-cycle implication
`define SRPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SRPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/srpq_pkg.sv
// ---------------------------------------------------------------------------
// Split ring packet queue package
// Codes, widths, descriptor layout and sequencer states shared by the block.
// ---------------------------------------------------------------------------
`default_nettype none

package srpq_pkg;

   localparam int SLOT_COUNT_DEF = 64;

   localparam int TX_SLOTS_W    = 6;
   localparam int TOTAL_SLOTS_W = 7;
   localparam int PTR_W         = 7;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 7;
   localparam int REQ_USER_W    = 3;
   localparam int RSP_USER_W    = 3;

   localparam logic [TX_SLOTS_W-1:0]    TX_SLOTS_RST    = 6'd32;
   localparam logic [TOTAL_SLOTS_W-1:0] TOTAL_SLOTS_RST = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_TX_SLOTS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_SLOTS = 2'd1;

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_REINIT = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;

   localparam logic [1:0] TAG_FREE = 2'd0;
   localparam logic [1:0] TAG_SEND = 2'd1;
   localparam logic [1:0] TAG_RECV = 2'd2;

   // first member lands in the highest bits: handle ends up at bit 0
   typedef struct packed {
      logic [31:0] argument;
      logic [15:0] channel;
      logic [31:0] length;
      logic [31:0] handle;
   } srpq_desc_type;

   localparam int DESC_W = $bits(srpq_desc_type);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_ACCESS,
      ST_CLEAR,
      ST_PROBE,
      ST_FINISH
   } srpq_state_type;

   // step a ring pointer, wrap to the ring base at the ring end
   function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] ptr,
                                                     input logic [PTR_W-1:0] base,
                                                     input logic [PTR_W-1:0] lim);
      logic [PTR_W:0] nxt;
      nxt = {1'b0, ptr} + {{PTR_W{1'b0}}, 1'b1};
      return (nxt < {1'b0, lim}) ? nxt[PTR_W-1:0] : base;
   endfunction

endpackage

`default_nettype wire

// File: hdl/split_ring_packet_queue.sv
// ---------------------------------------------------------------------------
// Split ring packet queue
// Descriptor slot table shared by a transmit ring and a receive ring.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one request per handshake; tuser picks the action and the ring,
//            tdata carries the descriptor stored by an add.
//   rsp_*  : one response per request, in order; tuser gives status and the
//            ring-full flag, tdata the removed descriptor (zero otherwise).
//   csr_*  : register writes (index 0 tx_slots, index 1 total_slots), always
//            ready; write only while no request is in flight.
// Sequence: requests are taken only in the idle state, so no new one is
//   accepted until the last has loaded its response. Add, remove and unused
//   codes walk read slot, write back, read the tail tag again, load the
//   output register, all through the single port pair of the tag memory.
//   A reinitialize adds a clearing sweep of one tag entry per cycle over
//   the freed range, tags 0 to min(max(tx_slots, total_slots), SLOT_COUNT) - 1.
// Reset: a clearing pass frees all SLOT_COUNT tags with req_tready low;
//   csr writes are taken during the pass.
// Stall: the output register holds a response while rsp_tready is low; the
//   next request is accepted and worked on, and waits to load until it drains.
// ---------------------------------------------------------------------------
`default_nettype none

module split_ring_packet_queue #(
   parameter int SLOT_COUNT = srpq_pkg::SLOT_COUNT_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // request channel
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // buf_handle[31:0], length[63:32], channel[79:64], user_arg[111:80]
   input  wire  [srpq_pkg::DESC_W-1:0]           req_tdata,
   // action[1:0], is_rx[2]
   input  wire  [srpq_pkg::REQ_USER_W-1:0]       req_tuser,
   // response channel
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // buf_handle_out[31:0], length_out[63:32], channel_out[79:64],
   // user_arg_out[111:80]
   output logic [srpq_pkg::DESC_W-1:0]           rsp_tdata,
   // status[1:0], ring_full[2]
   output logic [srpq_pkg::RSP_USER_W-1:0]       rsp_tuser,
   // configuration write channel
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [srpq_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [srpq_pkg::CSR_DATA_W-1:0]       csr_data
);

   import srpq_pkg::*;

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   // slot table: tags and descriptors, one write and one registered read each
   logic [1:0]    tag_mem  [SLOT_COUNT];
   srpq_desc_type desc_mem [SLOT_COUNT];

   logic [1:0]    tag_rd_ff;
   srpq_desc_type desc_rd_ff;

   logic             tag_rd_en;
   logic [IDX_W-1:0] tag_rd_addr;
   logic             tag_wr_en;
   logic [IDX_W-1:0] tag_wr_addr;
   logic [1:0]       tag_wr_data;
   logic             desc_wr_en;

   srpq_state_type state_ff, state_in;

   logic [TX_SLOTS_W-1:0]    tx_slots_ff, tx_slots_in;
   logic [TOTAL_SLOTS_W-1:0] total_slots_ff, total_slots_in;
   logic [PTR_W-1:0]         tx_head_ff, tx_head_in;
   logic [PTR_W-1:0]         tx_tail_ff, tx_tail_in;
   logic [PTR_W-1:0]         rx_head_ff, rx_head_in;
   logic [PTR_W-1:0]         rx_tail_ff, rx_tail_in;
   logic [CNT_W-1:0]         clr_cnt_ff, clr_cnt_in;
   logic [CNT_W-1:0]         clr_lim_ff, clr_lim_in;

   // captured request
   logic [1:0]    act_ff, act_in;
   logic          rx_ff, rx_in;
   srpq_desc_type req_desc_ff, req_desc_in;

   // working result
   logic [1:0]    res_status_ff, res_status_in;
   srpq_desc_type res_desc_ff, res_desc_in;

   // output register
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_full_ff, rsp_full_in;
   srpq_desc_type rsp_desc_ff, rsp_desc_in;

   // ring view of the captured request
   logic [PTR_W-1:0] ring_base;
   logic [PTR_W-1:0] ring_end;
   logic [1:0]       ring_busy;
   logic [PTR_W-1:0] ring_head;
   logic [PTR_W-1:0] ring_tail;
   logic [PTR_W-1:0] ring_ptr;
   logic             ptr_ok;
   logic             tail_ok;
   logic [PTR_W-1:0] in_ptr;
   logic [PTR_W-1:0] reinit_max;
   logic             req_fire;

   function automatic logic in_table(input logic [PTR_W-1:0] ptr);
      return 32'(ptr) < 32'(SLOT_COUNT);
   endfunction

   function automatic logic [IDX_W-1:0] slot_idx(input logic [PTR_W-1:0] ptr);
      logic [31:0] wide;
      wide = 32'(ptr);
      return wide[IDX_W-1:0];
   endfunction

   assign req_fire  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_desc_ff;
   assign rsp_tuser  = {rsp_full_ff, rsp_status_ff};

   assign ring_base = rx_ff ? {1'b0, tx_slots_ff} : '0;
   assign ring_end  = rx_ff ? total_slots_ff : {1'b0, tx_slots_ff};
   assign ring_busy = rx_ff ? TAG_RECV : TAG_SEND;
   assign ring_head = rx_ff ? rx_head_ff : tx_head_ff;
   assign ring_tail = rx_ff ? rx_tail_ff : tx_tail_ff;
   assign ring_ptr  = (act_ff == ACT_REMOVE) ? ring_head : ring_tail;
   assign ptr_ok    = in_table(ring_ptr);
   assign tail_ok   = in_table(ring_tail);

   // slot addressed by an incoming request, before it is captured
   always_comb begin
      if (req_tuser[1:0] == ACT_REMOVE) begin
         in_ptr = req_tuser[2] ? rx_head_ff : tx_head_ff;
      end else begin
         in_ptr = req_tuser[2] ? rx_tail_ff : tx_tail_ff;
      end
   end

   assign reinit_max = ({1'b0, tx_slots_ff} > total_slots_ff) ? {1'b0, tx_slots_ff}
                                                             : total_slots_ff;

   // memories
   always_ff @(posedge clock) begin
      if (tag_wr_en) begin
         tag_mem[tag_wr_addr] <= tag_wr_data;
      end
      if (desc_wr_en) begin
         desc_mem[tag_wr_addr] <= req_desc_ff;
      end
      if (tag_rd_en) begin
         tag_rd_ff  <= tag_mem[tag_rd_addr];
         desc_rd_ff <= desc_mem[tag_rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         tx_slots_ff    <= TX_SLOTS_RST;
         total_slots_ff <= TOTAL_SLOTS_RST;
         tx_head_ff     <= '0;
         tx_tail_ff     <= '0;
         rx_head_ff     <= {1'b0, TX_SLOTS_RST};
         rx_tail_ff     <= {1'b0, TX_SLOTS_RST};
         clr_cnt_ff     <= '0;
         clr_lim_ff     <= CNT_W'(SLOT_COUNT);
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tx_slots_ff    <= tx_slots_in;
         total_slots_ff <= total_slots_in;
         tx_head_ff     <= tx_head_in;
         tx_tail_ff     <= tx_tail_in;
         rx_head_ff     <= rx_head_in;
         rx_tail_ff     <= rx_tail_in;
         clr_cnt_ff     <= clr_cnt_in;
         clr_lim_ff     <= clr_lim_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      rx_ff         <= rx_in;
      req_desc_ff   <= req_desc_in;
      res_status_ff <= res_status_in;
      res_desc_ff   <= res_desc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_desc_ff   <= rsp_desc_in;
   end

   // register writes
   always_comb begin
      tx_slots_in    = tx_slots_ff;
      total_slots_in = total_slots_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TX_SLOTS:    tx_slots_in    = csr_data[TX_SLOTS_W-1:0];
            CSR_TOTAL_SLOTS: total_slots_in = csr_data[TOTAL_SLOTS_W-1:0];
            default:         ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      tx_head_in    = tx_head_ff;
      tx_tail_in    = tx_tail_ff;
      rx_head_in    = rx_head_ff;
      rx_tail_in    = rx_tail_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_lim_in    = clr_lim_ff;
      act_in        = act_ff;
      rx_in         = rx_ff;
      req_desc_in   = req_desc_ff;
      res_status_in = res_status_ff;
      res_desc_in   = res_desc_ff;
      rsp_status_in = rsp_status_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_desc_in   = rsp_desc_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      req_tready  = 1'b0;
      tag_rd_en   = 1'b0;
      tag_rd_addr = slot_idx(ring_tail);
      tag_wr_en   = 1'b0;
      tag_wr_addr = slot_idx(ring_ptr);
      tag_wr_data = TAG_FREE;
      desc_wr_en  = 1'b0;

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            // free one tag per cycle below the sweep limit
            tag_wr_addr = clr_cnt_ff[IDX_W-1:0];
            if (clr_cnt_ff < clr_lim_ff) begin
               tag_wr_en  = 1'b1;
               clr_cnt_in = clr_cnt_ff + CNT_W'(1);
            end else begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_PROBE;
            end
         end

         ST_IDLE: begin
            req_tready  = 1'b1;
            tag_rd_addr = slot_idx(in_ptr);
            if (req_fire) begin
               tag_rd_en   = 1'b1;
               act_in      = req_tuser[1:0];
               rx_in       = req_tuser[2];
               req_desc_in = req_tdata;
               state_in    = ST_ACCESS;
            end
         end

         ST_ACCESS: begin
            // slot data is back: decide, write back, move the pointer or reset
            res_status_in = STATUS_OK;
            res_desc_in   = '0;
            state_in      = ST_PROBE;
            case (act_ff)
               ACT_ADD: begin
                  if (ptr_ok && tag_rd_ff == TAG_FREE) begin
                     tag_wr_en   = 1'b1;
                     tag_wr_data = ring_busy;
                     desc_wr_en  = 1'b1;
                     if (rx_ff) begin
                        rx_tail_in = ring_advance(ring_tail, ring_base, ring_end);
                     end else begin
                        tx_tail_in = ring_advance(ring_tail, ring_base, ring_end);
                     end
                  end else begin
                     res_status_in = STATUS_OVERFLOW;
                  end
               end
               ACT_REMOVE: begin
                  if (ptr_ok && tag_rd_ff == ring_busy) begin
                     tag_wr_en   = 1'b1;
                     tag_wr_data = TAG_FREE;
                     res_desc_in = desc_rd_ff;
                     if (rx_ff) begin
                        rx_head_in = ring_advance(ring_head, ring_base, ring_end);
                     end else begin
                        tx_head_in = ring_advance(ring_head, ring_base, ring_end);
                     end
                  end else begin
                     res_status_in = STATUS_EMPTY;
                  end
               end
               ACT_REINIT: begin
                  tx_head_in = '0;
                  tx_tail_in = '0;
                  rx_head_in = {1'b0, tx_slots_ff};
                  rx_tail_in = {1'b0, tx_slots_ff};
                  clr_cnt_in = '0;
                  clr_lim_in = (32'(reinit_max) > 32'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT)
                                                                   : CNT_W'(reinit_max);
                  state_in   = ST_CLEAR;
               end
               default: ;
            endcase
         end

         ST_PROBE: begin
            // reread the tag at the final tail for the full flag
            tag_rd_en   = 1'b1;
            tag_rd_addr = slot_idx(ring_tail);
            state_in    = ST_FINISH;
         end

         ST_FINISH: begin
            // hold until the output register drains
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_desc_in   = res_desc_ff;
               rsp_full_in   = !tail_ok || (tag_rd_ff != TAG_FREE);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/srpq_checker.sv
// ---------------------------------------------------------------------------
// Split ring packet queue port checker
// Watches the top level's ports for sequencing and response consistency.
// ---------------------------------------------------------------------------
`default_nettype none

`include "split_ring_packet_queue_defines.svh"

module srpq_checker (
   input wire                                   clock,
   input wire                                   reset,
   input wire                                   req_tvalid,
   input wire                                   req_tready,
   input wire [srpq_pkg::DESC_W-1:0]            req_tdata,
   input wire [srpq_pkg::REQ_USER_W-1:0]        req_tuser,
   input wire                                   rsp_tvalid,
   input wire                                   rsp_tready,
   input wire [srpq_pkg::DESC_W-1:0]            rsp_tdata,
   input wire [srpq_pkg::RSP_USER_W-1:0]        rsp_tuser,
   input wire                                   csr_valid,
   input wire                                   csr_ready,
   input wire [srpq_pkg::CSR_IDX_W-1:0]         csr_index,
   input wire [srpq_pkg::CSR_DATA_W-1:0]        csr_data
);

   import srpq_pkg::*;

   logic unused_ok;
   assign unused_ok = ^{req_tdata, req_tuser, csr_valid, csr_ready, csr_index, csr_data};

   // stalled response holds
   `SRPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   // the sequencer is busy right after it takes a request
   `SRPQ_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready && !(unused_ok && !unused_ok), "request taken while one is in flight")

   // the clearing pass blocks requests right after reset
   `SRPQ_ASSERT_NOW(a_init_sweep, clock, reset, $fell(reset), !req_tready, "request taken during the reset clearing pass")

   // a failed request carries no descriptor
   `SRPQ_ASSERT_NOW(a_fail_zero, clock, reset, rsp_tvalid && (rsp_tuser[1:0] != STATUS_OK), rsp_tdata == '0, "failed request returned descriptor data")

   // an overflow leaves the tail slot occupied
   `SRPQ_ASSERT_NOW(a_overflow_full, clock, reset, rsp_tvalid && (rsp_tuser[1:0] == STATUS_OVERFLOW), rsp_tuser[2], "overflow without ring full")

endmodule

bind split_ring_packet_queue srpq_checker u_srpq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .csr_index  (csr_index),
   .csr_data   (csr_data)
);

`default_nettype wire
